>>> rtl/pvb_pkg.sv
// ============================================================================
// pvb_pkg: shared types and constants of the plan-view point binning unit
// Command codes, register indexes, the mapping configuration bundle and the
// result record that travels from the back end to the result queue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pvb_pkg;

   localparam int CMD_BITS      = 2;
   localparam int POS_BITS      = 32;
   localparam int IDX_OUT_BITS  = 6;
   localparam int CNT_OUT_BITS  = 16;
   localparam int SIZE_BITS     = 7;
   localparam int THR_BITS      = 16;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 3;

   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_ADD   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd2;

   localparam logic [REG_IDX_BITS-1:0] REG_ORIGIN_X  = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_ORIGIN_Z  = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_SCALE_X   = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_SCALE_Z   = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_GRID_COLS = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_GRID_ROWS = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD = 3'd6;

   typedef struct packed {
      logic signed [POS_BITS-1:0] origin_x;
      logic signed [POS_BITS-1:0] origin_z;
      logic [POS_BITS-1:0]        scale_x;
      logic [POS_BITS-1:0]        scale_z;
      logic [SIZE_BITS-1:0]       grid_cols;
      logic [SIZE_BITS-1:0]       grid_rows;
   } map_cfg_type;

   typedef struct packed {
      logic [IDX_OUT_BITS-1:0] hit_col;
      logic [IDX_OUT_BITS-1:0] hit_row;
      logic [CNT_OUT_BITS-1:0] bin_count;
      logic                    occupied;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/plan_view_point_binning_unit.sv
// ============================================================================
// plan_view_point_binning_unit: plan-view occupancy histogram
// Maps points onto a top-down grid, counts hits per bin, and serves clear
// and bin read requests through a CSR-configured mapping.
// ============================================================================
//
//   Channel   Ports              Handshake
//   request   req_*              accepted when req_push and not req_full
//   response  rsp_*              accepted when rsp_pop and not rsp_empty
//   csr       csr_*              written when psel, penable, pwrite, pready
//
// One request per cycle is sustained while responses are taken and no clear
// sweep runs. The mapping pipeline registers origin offset, scale product,
// clamped bin and bin address, the middle queue holds the entry, and the
// update stage registers the entry and its store read; the response then
// enters the response queue. The counter store has one write and one read
// port, which sets that rate. A clear request sweeps every bin to zero, and
// the same sweep runs after reset; requests queue meanwhile.
// Either side may stall on its own through the internal queues.
`timescale 1ns / 1ps
`default_nettype none

module plan_view_point_binning_unit #(
   parameter int MAX_COLS   = 64,
   parameter int MAX_ROWS   = 64,
   parameter int COUNT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [pvb_pkg::CMD_BITS-1:0]         req_command,
   input  logic signed [pvb_pkg::POS_BITS-1:0]  req_x_pos,
   input  logic signed [pvb_pkg::POS_BITS-1:0]  req_z_pos,
   input  logic [pvb_pkg::IDX_OUT_BITS-1:0]     req_read_col,
   input  logic [pvb_pkg::IDX_OUT_BITS-1:0]     req_read_row,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [pvb_pkg::IDX_OUT_BITS-1:0]     rsp_hit_col,
   output logic [pvb_pkg::IDX_OUT_BITS-1:0]     rsp_hit_row,
   output logic [pvb_pkg::CNT_OUT_BITS-1:0]     rsp_bin_count,
   output logic                                 rsp_occupied,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pvb_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [pvb_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [pvb_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   import pvb_pkg::*;

   localparam int COL_BITS   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_BITS   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ADDR_BITS  = $clog2(MAX_COLS * MAX_ROWS);
   localparam int ENTRY_BITS = CMD_BITS + COL_BITS + ROW_BITS + ADDR_BITS;
   localparam int RSP_BITS   = $bits(rsp_type);

   logic signed [POS_BITS-1:0] origin_x_ff, origin_z_ff;
   logic [POS_BITS-1:0]        scale_x_ff, scale_z_ff;
   logic [SIZE_BITS-1:0]       grid_cols_ff, grid_rows_ff;
   logic [THR_BITS-1:0]        threshold_ff;

   logic [REG_IDX_BITS-1:0]    reg_idx;
   logic                       csr_wr;
   map_cfg_type                map_cfg;

   logic                       mid_push, mid_full, mid_pop, mid_empty;
   logic [ENTRY_BITS-1:0]      mid_in, mid_head;
   logic                       out_push, out_full;
   rsp_type                    out_rsp, rsp_head;
   logic [RSP_BITS-1:0]        rsp_head_bits;

   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_z_ff  <= '0;
         scale_x_ff   <= 32'd65536;
         scale_z_ff   <= 32'd65536;
         grid_cols_ff <= 7'd64;
         grid_rows_ff <= 7'd64;
         threshold_ff <= 16'd2;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_ORIGIN_X:  origin_x_ff  <= csr_pwdata;
            REG_ORIGIN_Z:  origin_z_ff  <= csr_pwdata;
            REG_SCALE_X:   scale_x_ff   <= csr_pwdata;
            REG_SCALE_Z:   scale_z_ff   <= csr_pwdata;
            REG_GRID_COLS: grid_cols_ff <= csr_pwdata[SIZE_BITS-1:0];
            REG_GRID_ROWS: grid_rows_ff <= csr_pwdata[SIZE_BITS-1:0];
            REG_THRESHOLD: threshold_ff <= csr_pwdata[THR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ORIGIN_X:  csr_prdata = origin_x_ff;
         REG_ORIGIN_Z:  csr_prdata = origin_z_ff;
         REG_SCALE_X:   csr_prdata = scale_x_ff;
         REG_SCALE_Z:   csr_prdata = scale_z_ff;
         REG_GRID_COLS: csr_prdata = CSR_DATA_BITS'(grid_cols_ff);
         REG_GRID_ROWS: csr_prdata = CSR_DATA_BITS'(grid_rows_ff);
         REG_THRESHOLD: csr_prdata = CSR_DATA_BITS'(threshold_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_comb begin
      map_cfg.origin_x  = origin_x_ff;
      map_cfg.origin_z  = origin_z_ff;
      map_cfg.scale_x   = scale_x_ff;
      map_cfg.scale_z   = scale_z_ff;
      map_cfg.grid_cols = grid_cols_ff;
      map_cfg.grid_rows = grid_rows_ff;
   end

   pvb_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (map_cfg),
      .in_push     (req_push),
      .in_full     (req_full),
      .in_command  (req_command),
      .in_x_pos    (req_x_pos),
      .in_z_pos    (req_z_pos),
      .in_read_col (req_read_col),
      .in_read_row (req_read_row),
      .out_push    (mid_push),
      .out_full    (mid_full),
      .out_entry   (mid_in)
   );

   pvb_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (4)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in),
      .full      (mid_full),
      .pop       (mid_pop),
      .head      (mid_head),
      .empty     (mid_empty)
   );

   pvb_back #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .threshold (threshold_ff),
      .in_empty  (mid_empty),
      .in_entry  (mid_head),
      .in_pop    (mid_pop),
      .out_push  (out_push),
      .out_full  (out_full),
      .out_rsp   (out_rsp)
   );

   pvb_queue #(
      .WIDTH (RSP_BITS),
      .DEPTH (4)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_rsp),
      .full      (out_full),
      .pop       (rsp_pop),
      .head      (rsp_head_bits),
      .empty     (rsp_empty)
   );

   assign rsp_head      = rsp_head_bits;
   assign rsp_hit_col   = rsp_head.hit_col;
   assign rsp_hit_row   = rsp_head.hit_row;
   assign rsp_bin_count = rsp_head.bin_count;
   assign rsp_occupied  = rsp_head.occupied;

endmodule

`default_nettype wire

>>> rtl/pvb_queue.sv
// ============================================================================
// pvb_queue: small synchronous queue
// Register-based circular buffer with a count; the head entry is visible
// whenever the queue is not empty.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pvb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    store_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/pvb_front.sv
// ============================================================================
// pvb_front: request classification and coordinate mapping
// Four-stage pipeline: origin offset, scale multiply, clamp into the grid
// in use, and bin address. Each request leaves as one queue entry.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pvb_front #(
   parameter  int MAX_COLS    = 64,
   parameter  int MAX_ROWS    = 64,
   localparam int COL_BITS    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int ROW_BITS    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   localparam int ADDR_BITS   = $clog2(MAX_COLS * MAX_ROWS),
   localparam int ENTRY_BITS  = pvb_pkg::CMD_BITS + COL_BITS + ROW_BITS + ADDR_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pvb_pkg::map_cfg_type                 cfg,
   input  logic                                 in_push,
   output logic                                 in_full,
   input  logic [pvb_pkg::CMD_BITS-1:0]         in_command,
   input  logic signed [pvb_pkg::POS_BITS-1:0]  in_x_pos,
   input  logic signed [pvb_pkg::POS_BITS-1:0]  in_z_pos,
   input  logic [pvb_pkg::IDX_OUT_BITS-1:0]     in_read_col,
   input  logic [pvb_pkg::IDX_OUT_BITS-1:0]     in_read_row,
   output logic                                 out_push,
   input  logic                                 out_full,
   output logic [ENTRY_BITS-1:0]                out_entry
);

   import pvb_pkg::*;

   logic advance;

   logic                      s1_valid_ff, s1_valid_in;
   logic [CMD_BITS-1:0]       s1_cmd_ff;
   logic [POS_BITS:0]         s1_dx_ff, s1_dz_ff;
   logic [IDX_OUT_BITS-1:0]   s1_rcol_ff, s1_rrow_ff;

   logic                      s2_valid_ff;
   logic [CMD_BITS-1:0]       s2_cmd_ff;
   logic                      s2_negx_ff, s2_negz_ff;
   logic [2*POS_BITS-1:0]     s2_px_ff, s2_pz_ff, s2_px_in, s2_pz_in;
   logic [IDX_OUT_BITS-1:0]   s2_rcol_ff, s2_rrow_ff;

   logic                      s3_valid_ff;
   logic [CMD_BITS-1:0]       s3_cmd_ff;
   logic [COL_BITS-1:0]       s3_col_ff, s3_col_in;
   logic [ROW_BITS-1:0]       s3_row_ff, s3_row_in;

   logic                      s4_valid_ff;
   logic [CMD_BITS-1:0]       s4_cmd_ff;
   logic [COL_BITS-1:0]       s4_col_ff;
   logic [ROW_BITS-1:0]       s4_row_ff;
   logic [ADDR_BITS-1:0]      s4_addr_ff, s4_addr_in;

   logic [COL_BITS-1:0]       cols_m1, add_col, read_col;
   logic [ROW_BITS-1:0]       rows_m1, add_row, read_row;

   assign advance     = !s4_valid_ff || !out_full;
   assign in_full     = !advance;
   assign s1_valid_in = in_push;
   assign out_push    = s4_valid_ff;
   assign out_entry   = {s4_cmd_ff, s4_col_ff, s4_row_ff, s4_addr_ff};

   always_comb begin
      priority if (cfg.grid_cols == '0) begin
         cols_m1 = '0;
      end else if (32'(cfg.grid_cols) > 32'(MAX_COLS)) begin
         cols_m1 = COL_BITS'(MAX_COLS - 1);
      end else begin
         cols_m1 = COL_BITS'(cfg.grid_cols - 7'd1);
      end
      priority if (cfg.grid_rows == '0) begin
         rows_m1 = '0;
      end else if (32'(cfg.grid_rows) > 32'(MAX_ROWS)) begin
         rows_m1 = ROW_BITS'(MAX_ROWS - 1);
      end else begin
         rows_m1 = ROW_BITS'(cfg.grid_rows - 7'd1);
      end
   end

   assign s2_px_in = s1_dx_ff[POS_BITS-1:0] * cfg.scale_x;
   assign s2_pz_in = s1_dz_ff[POS_BITS-1:0] * cfg.scale_z;

   always_comb begin
      if (s2_negx_ff) begin
         add_col = '0;
      end else if (s2_px_ff[2*POS_BITS-1:POS_BITS] > 32'(cols_m1)) begin
         add_col = cols_m1;
      end else begin
         add_col = s2_px_ff[POS_BITS+COL_BITS-1:POS_BITS];
      end
      if (s2_negz_ff) begin
         add_row = '0;
      end else if (s2_pz_ff[2*POS_BITS-1:POS_BITS] > 32'(rows_m1)) begin
         add_row = rows_m1;
      end else begin
         add_row = s2_pz_ff[POS_BITS+ROW_BITS-1:POS_BITS];
      end
      read_col = (32'(s2_rcol_ff) > 32'(cols_m1)) ? cols_m1 : COL_BITS'(s2_rcol_ff);
      read_row = (32'(s2_rrow_ff) > 32'(rows_m1)) ? rows_m1 : ROW_BITS'(s2_rrow_ff);
      if (s2_cmd_ff == CMD_ADD) begin
         s3_col_in = add_col;
         s3_row_in = add_row;
      end else if (s2_cmd_ff == CMD_READ) begin
         s3_col_in = read_col;
         s3_row_in = read_row;
      end else begin
         s3_col_in = '0;
         s3_row_in = '0;
      end
   end

   assign s4_addr_in = ADDR_BITS'(s3_row_ff) * ADDR_BITS'(MAX_COLS) + ADDR_BITS'(s3_col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff  <= in_command;
         s1_dx_ff   <= {in_x_pos[POS_BITS-1], in_x_pos}
                       - {cfg.origin_x[POS_BITS-1], cfg.origin_x};
         s1_dz_ff   <= {in_z_pos[POS_BITS-1], in_z_pos}
                       - {cfg.origin_z[POS_BITS-1], cfg.origin_z};
         s1_rcol_ff <= in_read_col;
         s1_rrow_ff <= in_read_row;

         s2_cmd_ff  <= s1_cmd_ff;
         s2_negx_ff <= s1_dx_ff[POS_BITS];
         s2_negz_ff <= s1_dz_ff[POS_BITS];
         s2_px_ff   <= s2_px_in;
         s2_pz_ff   <= s2_pz_in;
         s2_rcol_ff <= s1_rcol_ff;
         s2_rrow_ff <= s1_rrow_ff;

         s3_cmd_ff  <= s2_cmd_ff;
         s3_col_ff  <= s3_col_in;
         s3_row_ff  <= s3_row_in;

         s4_cmd_ff  <= s3_cmd_ff;
         s4_col_ff  <= s3_col_ff;
         s4_row_ff  <= s3_row_ff;
         s4_addr_ff <= s4_addr_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/pvb_back.sv
// ============================================================================
// pvb_back: bin counter store and update engine
// Issues a store read per request, then increments or reports the bin with
// forwarding of the previous write. Clears the store with a sweep.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pvb_back #(
   parameter  int MAX_COLS   = 64,
   parameter  int MAX_ROWS   = 64,
   parameter  int COUNT_BITS = 16,
   localparam int COL_BITS   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int ROW_BITS   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   localparam int ADDR_BITS  = $clog2(MAX_COLS * MAX_ROWS),
   localparam int ENTRY_BITS = pvb_pkg::CMD_BITS + COL_BITS + ROW_BITS + ADDR_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [pvb_pkg::THR_BITS-1:0]     threshold,
   input  logic                             in_empty,
   input  logic [ENTRY_BITS-1:0]            in_entry,
   output logic                             in_pop,
   output logic                             out_push,
   input  logic                             out_full,
   output pvb_pkg::rsp_type                 out_rsp
);

   import pvb_pkg::*;

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam logic ST_RUN   = 1'b0;
   localparam logic ST_SWEEP = 1'b1;

   logic [COUNT_BITS-1:0] mem_ff [DEPTH];
   logic [COUNT_BITS-1:0] rd_data_ff;

   logic                  state_ff, state_in;
   logic [ADDR_BITS-1:0]  sweep_addr_ff, sweep_addr_in;

   logic                  u_valid_ff, u_valid_in;
   logic [CMD_BITS-1:0]   u_cmd_ff;
   logic [COL_BITS-1:0]   u_col_ff;
   logic [ROW_BITS-1:0]   u_row_ff;
   logic [ADDR_BITS-1:0]  u_addr_ff;

   logic                  fwd_valid_ff, fwd_valid_in;
   logic [ADDR_BITS-1:0]  fwd_addr_ff;
   logic [COUNT_BITS-1:0] fwd_data_ff;

   logic [CMD_BITS-1:0]   h_cmd;
   logic [COL_BITS-1:0]   h_col;
   logic [ROW_BITS-1:0]   h_row;
   logic [ADDR_BITS-1:0]  h_addr;

   logic                  u_fire;
   logic                  issue;
   logic [COUNT_BITS-1:0] cur;
   logic [COUNT_BITS-1:0] inc;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [COUNT_BITS-1:0] wr_data;

   assign {h_cmd, h_col, h_row, h_addr} = in_entry;

   assign u_fire = u_valid_ff && !out_full;
   assign issue  = (state_ff == ST_RUN) && !in_empty
                   && !(u_valid_ff && (u_cmd_ff == CMD_CLEAR))
                   && (!u_valid_ff || u_fire);
   assign in_pop   = issue;
   assign out_push = u_fire;

   assign cur = (fwd_valid_ff && (fwd_addr_ff == u_addr_ff)) ? fwd_data_ff : rd_data_ff;
   assign inc = (cur == {COUNT_BITS{1'b1}}) ? cur : cur + 1'b1;

   always_comb begin
      out_rsp = '0;
      if (u_cmd_ff == CMD_ADD) begin
         out_rsp.hit_col   = IDX_OUT_BITS'(u_col_ff);
         out_rsp.hit_row   = IDX_OUT_BITS'(u_row_ff);
         out_rsp.bin_count = CNT_OUT_BITS'(inc);
         out_rsp.occupied  = 32'(inc) > 32'(threshold);
      end else if (u_cmd_ff == CMD_READ) begin
         out_rsp.bin_count = CNT_OUT_BITS'(cur);
         out_rsp.occupied  = 32'(cur) > 32'(threshold);
      end
   end

   always_comb begin
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      wr_en         = 1'b0;
      wr_addr       = u_addr_ff;
      wr_data       = inc;
      fwd_valid_in  = fwd_valid_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            wr_en        = 1'b1;
            wr_addr      = sweep_addr_ff;
            wr_data      = '0;
            fwd_valid_in = 1'b0;
            if (sweep_addr_ff == ADDR_BITS'(DEPTH - 1)) begin
               state_in      = ST_RUN;
               sweep_addr_in = '0;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end
         default: begin
            if (u_fire) begin
               wr_en        = (u_cmd_ff == CMD_ADD);
               fwd_valid_in = (u_cmd_ff == CMD_ADD);
               if (u_cmd_ff == CMD_CLEAR) begin
                  state_in = ST_SWEEP;
               end
            end
         end
      endcase
      if (issue) begin
         u_valid_in = 1'b1;
      end else if (u_fire) begin
         u_valid_in = 1'b0;
      end else begin
         u_valid_in = u_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
         u_valid_ff    <= 1'b0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         u_valid_ff    <= u_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         u_cmd_ff  <= h_cmd;
         u_col_ff  <= h_col;
         u_row_ff  <= h_row;
         u_addr_ff <= h_addr;
      end
      if (u_fire) begin
         fwd_addr_ff <= u_addr_ff;
         fwd_data_ff <= inc;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= mem_ff[h_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/pvb_checker.sv
// ============================================================================
// pvb_checker: port-level checks of the plan-view point binning unit
// Watches the response queue and the CSR port over time.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pvb_checker #(
   parameter int COUNT_BITS = 16
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [5:0]  rsp_hit_col,
   input wire logic [5:0]  rsp_hit_row,
   input wire logic [15:0] rsp_bin_count,
   input wire logic        rsp_occupied,
   input wire logic        csr_psel,
   input wire logic        csr_penable,
   input wire logic        csr_pwrite,
   input wire logic [4:0]  csr_paddr,
   input wire logic [31:0] csr_pwdata,
   input wire logic [31:0] csr_prdata,
   input wire logic        csr_pready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response queue not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_hit_col)
         && $stable(rsp_hit_row) && $stable(rsp_bin_count) && $stable(rsp_occupied)))
      else $error("waiting response changed before it was taken");

   a_zero_count_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_bin_count == 16'd0) && (COUNT_BITS <= 16)) |-> !rsp_occupied)
      else $error("empty bin reported as occupied");

   a_threshold_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready
         && (csr_paddr == {pvb_pkg::REG_THRESHOLD, 2'b00}))
      |=> ((csr_paddr != {pvb_pkg::REG_THRESHOLD, 2'b00})
         || (csr_prdata == {16'd0, $past(csr_pwdata[15:0])})))
      else $error("threshold register read back differs from write");

endmodule

bind plan_view_point_binning_unit pvb_checker #(
   .COUNT_BITS (COUNT_BITS)
) u_pvb_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_hit_col   (rsp_hit_col),
   .rsp_hit_row   (rsp_hit_row),
   .rsp_bin_count (rsp_bin_count),
   .rsp_occupied  (rsp_occupied),
   .csr_psel      (csr_psel),
   .csr_penable   (csr_penable),
   .csr_pwrite    (csr_pwrite),
   .csr_paddr     (csr_paddr),
   .csr_pwdata    (csr_pwdata),
   .csr_prdata    (csr_prdata),
   .csr_pready    (csr_pready)
);

`default_nettype wire

>>> tb/tb_plan_view_point_binning_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the plan-view point binning unit
// Drives add, read, clear and no-op requests through the request port and
// checks every response against a model of the occupancy histogram held in
// the testbench or against the value given with a directed request. The grid
// mapping is reconfigured over the CSR port between phases, covering zero and
// oversized grids, extreme origins and scales, repeated hits on one bin, long
// response stalls and random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_plan_view_point_binning_unit;
   import pvb_pkg::*;

   localparam int GRID_COLS = 64;
   localparam int GRID_ROWS = 64;
   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;
   localparam logic [CMD_BITS-1:0] CMD_NONE = 2'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 3'd7;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int SAME_BIN_ADDS = 40;
   localparam int DIR_COUNT = 17;

   typedef struct packed {
      logic [CMD_BITS-1:0]        command;
      logic signed [POS_BITS-1:0] x_pos;
      logic signed [POS_BITS-1:0] z_pos;
      logic [IDX_OUT_BITS-1:0]    read_col;
      logic [IDX_OUT_BITS-1:0]    read_row;
   } bin_req_type;

   typedef struct packed {
      bin_req_type req;
      logic        typed;
      rsp_type     want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_push;
   logic req_full;
   logic [CMD_BITS-1:0] req_command;
   logic signed [POS_BITS-1:0] req_x_pos;
   logic signed [POS_BITS-1:0] req_z_pos;
   logic [IDX_OUT_BITS-1:0] req_read_col;
   logic [IDX_OUT_BITS-1:0] req_read_row;
   logic rsp_empty;
   logic rsp_pop;
   logic [IDX_OUT_BITS-1:0] rsp_hit_col;
   logic [IDX_OUT_BITS-1:0] rsp_hit_row;
   logic [CNT_OUT_BITS-1:0] rsp_bin_count;
   logic rsp_occupied;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   logic signed [POS_BITS-1:0] cfg_origin_x = '0;
   logic signed [POS_BITS-1:0] cfg_origin_z = '0;
   logic [POS_BITS-1:0] cfg_scale_x = 32'd65536;
   logic [POS_BITS-1:0] cfg_scale_z = 32'd65536;
   logic [SIZE_BITS-1:0] cfg_cols = 7'd64;
   logic [SIZE_BITS-1:0] cfg_rows = 7'd64;
   logic [THR_BITS-1:0] cfg_threshold = 16'd2;
   logic [COUNT_BITS-1:0] bin_store [GRID_COLS*GRID_ROWS];

   rsp_type histogram_rsp_q[$];
   int error_count = 0;
   int idle_pct = 12;
   logic rsp_hold_req = 1'b0;
   int quiet_cycles = 0;

   plan_view_point_binning_unit #(
      .MAX_COLS(GRID_COLS),
      .MAX_ROWS(GRID_ROWS),
      .COUNT_BITS(COUNT_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_command(req_command),
      .req_x_pos(req_x_pos),
      .req_z_pos(req_z_pos),
      .req_read_col(req_read_col),
      .req_read_row(req_read_row),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_hit_col(rsp_hit_col),
      .rsp_hit_row(rsp_hit_row),
      .rsp_bin_count(rsp_bin_count),
      .rsp_occupied(rsp_occupied),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned grid_extent(logic [SIZE_BITS-1:0] size, int unsigned limit);
      if (size == 0) return 1;
      if (size > limit) return limit;
      return size;
   endfunction

   function automatic int unsigned axis_bin(logic signed [POS_BITS-1:0] pos,
                                            logic signed [POS_BITS-1:0] origin,
                                            logic [POS_BITS-1:0] scale, int unsigned size);
      longint offset;
      logic [63:0] product;
      offset = longint'(pos) - longint'(origin);
      if (offset < 0) return 0;
      product = 64'(offset) * {32'd0, scale};
      if (product[63:32] > size - 1) return size - 1;
      return product[63:32];
   endfunction

   function automatic rsp_type histogram_step(bin_req_type r);
      rsp_type res;
      int unsigned cols;
      int unsigned rows;
      int unsigned col;
      int unsigned row;
      int unsigned slot;
      res = '0;
      cols = grid_extent(cfg_cols, GRID_COLS);
      rows = grid_extent(cfg_rows, GRID_ROWS);
      case (r.command)
         CMD_CLEAR: begin
            foreach (bin_store[i]) bin_store[i] = '0;
         end
         CMD_ADD: begin
            col = axis_bin(r.x_pos, cfg_origin_x, cfg_scale_x, cols);
            row = axis_bin(r.z_pos, cfg_origin_z, cfg_scale_z, rows);
            slot = row * GRID_COLS + col;
            if (bin_store[slot] != COUNT_FULL) bin_store[slot] = bin_store[slot] + 1'b1;
            res.hit_col = col[IDX_OUT_BITS-1:0];
            res.hit_row = row[IDX_OUT_BITS-1:0];
            res.bin_count = bin_store[slot];
            res.occupied = bin_store[slot] > cfg_threshold;
         end
         CMD_READ: begin
            col = (r.read_col > cols - 1) ? cols - 1 : r.read_col;
            row = (r.read_row > rows - 1) ? rows - 1 : r.read_row;
            slot = row * GRID_COLS + col;
            res.bin_count = bin_store[slot];
            res.occupied = bin_store[slot] > cfg_threshold;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Most positions are aimed into the grid by inverting the scale, the rest
   // are raw words, extremes or points just below the origin.
   function automatic logic [POS_BITS-1:0] random_pos(logic [POS_BITS-1:0] origin,
                                                      logic [POS_BITS-1:0] scale,
                                                      int unsigned size);
      logic [63:0] span;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) return $urandom;
      if (pick < 25) return (pick % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      if (pick < 35) return origin - $urandom_range(1, 1 << 17);
      if (scale == 0) return origin + $urandom;
      span = {32'($urandom_range(0, size + 1)), 32'($urandom)} / {32'd0, scale};
      return origin + span[31:0];
   endfunction

   function automatic bin_req_type random_request();
      bin_req_type r;
      int unsigned pick;
      int unsigned cols;
      int unsigned rows;
      pick = $urandom_range(0, 127);
      cols = grid_extent(cfg_cols, GRID_COLS);
      rows = grid_extent(cfg_rows, GRID_ROWS);
      r.command = (pick == 0) ? CMD_CLEAR : (pick < 3) ? CMD_NONE :
                  (pick < 40) ? CMD_READ : CMD_ADD;
      r.x_pos = random_pos(cfg_origin_x, cfg_scale_x, cols);
      r.z_pos = random_pos(cfg_origin_z, cfg_scale_z, rows);
      r.read_col = (pick % 2) ? 6'($urandom) : 6'($urandom_range(0, cols - 1));
      r.read_row = (pick % 3) ? 6'($urandom_range(0, rows - 1)) : 6'($urandom);
      return r;
   endfunction

   function automatic dir_row_type dir_entry(logic [CMD_BITS-1:0] cmd, logic [31:0] x,
                                             logic [31:0] z, logic [5:0] col, logic [5:0] row,
                                             logic typed, logic [5:0] hit_col,
                                             logic [5:0] hit_row, logic [15:0] count,
                                             logic occupied);
      dir_row_type d;
      d.req = '{cmd, x, z, col, row};
      d.typed = typed;
      d.want = '{hit_col, hit_row, count, occupied};
      return d;
   endfunction

   task automatic send_request(input bin_req_type r, input logic typed,
                               input rsp_type typed_rsp);
      rsp_type predicted;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push = 1'b1;
      req_command = r.command;
      req_x_pos = r.x_pos;
      req_z_pos = r.z_pos;
      req_read_col = r.read_col;
      req_read_row = r.read_row;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predicted = histogram_step(r);
      histogram_rsp_q = {histogram_rsp_q, (typed ? typed_rsp : predicted)};
      @(negedge clock);
      req_push = 1'b0;
   endtask

   task automatic run_random(input int count);
      repeat (count) send_request(random_request(), 1'b0, '0);
   endtask

   task automatic settle();
      while (histogram_rsp_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      case (idx)
         REG_ORIGIN_X:  cfg_origin_x = value;
         REG_ORIGIN_Z:  cfg_origin_z = value;
         REG_SCALE_X:   cfg_scale_x = value;
         REG_SCALE_Z:   cfg_scale_z = value;
         REG_GRID_COLS: cfg_cols = value[SIZE_BITS-1:0];
         REG_GRID_ROWS: cfg_rows = value[SIZE_BITS-1:0];
         REG_THRESHOLD: cfg_threshold = value[THR_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_read_check(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] want);
      logic [31:0] got;
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = {idx, 2'b00};
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      if (got !== want) begin
         $error("register %0d: expected %0h, got %0h", idx, want, got);
         error_count++;
      end
   endtask

   task automatic set_grid_config(input logic [31:0] origin_x, input logic [31:0] origin_z,
                                  input logic [31:0] scale_x, input logic [31:0] scale_z,
                                  input logic [6:0] cols, input logic [6:0] rows,
                                  input logic [15:0] threshold);
      settle();
      csr_write(REG_ORIGIN_X, origin_x);
      csr_write(REG_ORIGIN_Z, origin_z);
      csr_write(REG_SCALE_X, scale_x);
      csr_write(REG_SCALE_Z, scale_z);
      csr_write(REG_GRID_COLS, {25'd0, cols});
      csr_write(REG_GRID_ROWS, {25'd0, rows});
      csr_write(REG_THRESHOLD, {16'd0, threshold});
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      csr_read_check(REG_ORIGIN_X, origin_x);
      csr_read_check(REG_ORIGIN_Z, origin_z);
      csr_read_check(REG_SCALE_X, scale_x);
      csr_read_check(REG_SCALE_Z, scale_z);
      csr_read_check(REG_GRID_COLS, {25'd0, cols});
      csr_read_check(REG_GRID_ROWS, {25'd0, rows});
      csr_read_check(REG_THRESHOLD, {16'd0, threshold});
   endtask

   initial begin
      int hold_count;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_pop = 1'b0;
            for (hold_count = 0; hold_count < RSP_HOLD_CYCLES; hold_count++) @(negedge clock);
            rsp_hold_req = 1'b0;
         end
         rsp_pop = ($urandom_range(0, 99) >= idle_pct);
      end
   end

   always @(posedge clock) begin : check_response
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (histogram_rsp_q.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = histogram_rsp_q.pop_front();
            if (rsp_hit_col !== want.hit_col) begin
               $error("hit_col: expected %0d, got %0d", want.hit_col, rsp_hit_col);
               error_count++;
            end
            if (rsp_hit_row !== want.hit_row) begin
               $error("hit_row: expected %0d, got %0d", want.hit_row, rsp_hit_row);
               error_count++;
            end
            if (rsp_bin_count !== want.bin_count) begin
               $error("bin_count: expected %0d, got %0d", want.bin_count, rsp_bin_count);
               error_count++;
            end
            if (rsp_occupied !== want.occupied) begin
               $error("occupied: expected %0d, got %0d", want.occupied, rsp_occupied);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      dir_row_type directed_rows [DIR_COUNT];
      int phase;
      reset = 1'b1;
      req_push = 1'b0;
      req_command = CMD_CLEAR;
      req_x_pos = '0;
      req_z_pos = '0;
      req_read_col = '0;
      req_read_row = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      foreach (bin_store[i]) bin_store[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_rows = '{
         dir_entry(CMD_READ, 32'h0, 32'h0, 6'd0, 6'd0, 1'b1, 6'd0, 6'd0, 16'd0, 1'b0),
         dir_entry(CMD_ADD, 32'h0, 32'h0, 6'd0, 6'd0, 1'b1, 6'd0, 6'd0, 16'd1, 1'b0),
         dir_entry(CMD_ADD, 32'h0, 32'h0, 6'd0, 6'd0, 1'b1, 6'd0, 6'd0, 16'd2, 1'b0),
         dir_entry(CMD_ADD, 32'h0, 32'h0, 6'd0, 6'd0, 1'b1, 6'd0, 6'd0, 16'd3, 1'b1),
         dir_entry(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd0, 6'd0, 1'b1,
                   6'd63, 6'd63, 16'd1, 1'b0),
         dir_entry(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 6'd0, 6'd0, 1'b1,
                   6'd0, 6'd0, 16'd4, 1'b1),
         dir_entry(CMD_ADD, 32'h0005_8000, 32'h0009_4000, 6'd0, 6'd0, 1'b1,
                   6'd5, 6'd9, 16'd1, 1'b0),
         dir_entry(CMD_ADD, 32'hFFFF_FFFF, 32'h0000_FFFF, 6'd0, 6'd0, 1'b1,
                   6'd0, 6'd0, 16'd5, 1'b1),
         dir_entry(CMD_ADD, 32'h0001_2345, 32'h0001_FFFF, 6'd0, 6'd0, 1'b0,
                   6'd0, 6'd0, 16'd0, 1'b0),
         dir_entry(CMD_READ, 32'h0, 32'h0, 6'd63, 6'd63, 1'b1, 6'd0, 6'd0, 16'd1, 1'b0),
         dir_entry(CMD_READ, 32'h0, 32'h0, 6'd0, 6'd0, 1'b1, 6'd0, 6'd0, 16'd5, 1'b1),
         dir_entry(CMD_READ, 32'h0, 32'h0, 6'd1, 6'd1, 1'b0, 6'd0, 6'd0, 16'd0, 1'b0),
         dir_entry(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 6'd63, 1'b1,
                   6'd0, 6'd0, 16'd0, 1'b0),
         dir_entry(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 6'd63, 1'b1,
                   6'd0, 6'd0, 16'd0, 1'b0),
         dir_entry(CMD_READ, 32'h0, 32'h0, 6'd0, 6'd0, 1'b1, 6'd0, 6'd0, 16'd0, 1'b0),
         dir_entry(CMD_READ, 32'h0, 32'h0, 6'd63, 6'd63, 1'b1, 6'd0, 6'd0, 16'd0, 1'b0),
         dir_entry(CMD_ADD, 32'h003F_0000, 32'h0040_0000, 6'd0, 6'd0, 1'b1,
                   6'd63, 6'd63, 16'd1, 1'b0)
      };
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end

      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               set_grid_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                               7'd0, 7'd127, 16'd0);
               run_random(110);
            end
            1: begin
               set_grid_config($urandom_range(0, 1 << 20) - (1 << 19),
                               $urandom_range(0, 1 << 20) - (1 << 19),
                               $urandom_range(1 << 14, 1 << 18),
                               $urandom_range(1 << 14, 1 << 18),
                               7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                               16'($urandom_range(0, 4)));
               run_random(110);
            end
            2: begin
               set_grid_config(32'h0, 32'h0, 32'h0010_0000, 32'h0000_1000,
                               7'd64, 7'd1, 16'hFFFF);
               run_random(110);
            end
            3: begin
               // Every point lands in the first bin.
               set_grid_config(32'h0, 32'h0, 32'h0, 32'h0, 7'd64, 7'd64, 16'hFFFE);
               send_request('{CMD_CLEAR, 32'h0, 32'h0, 6'd0, 6'd0}, 1'b0, '0);
               repeat (SAME_BIN_ADDS) begin
                  send_request('{CMD_ADD, $urandom, $urandom, 6'd0, 6'd0}, 1'b0, '0);
               end
               send_request('{CMD_READ, 32'h0, 32'h0, 6'd0, 6'd0}, 1'b0, '0);
            end
            4: begin
               set_grid_config($urandom, $urandom, $urandom, $urandom,
                               7'd1, 7'd1, 16'hFFFF);
               run_random(100);
            end
            5: begin
               set_grid_config($urandom, $urandom, $urandom, $urandom,
                               7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                               16'($urandom_range(0, 6)));
               idle_pct = 0;
               run_random(120);
               idle_pct = 12;
            end
            default: begin
               set_grid_config(32'h0, 32'h0, 32'd65536, 32'd65536, 7'd64, 7'd64, 16'd2);
               rsp_hold_req = 1'b1;
               run_random(150);
            end
         endcase
      end

      settle();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> plan_view_point_binning_unit.f
rtl/pvb_pkg.sv
rtl/pvb_queue.sv
rtl/pvb_front.sv
rtl/pvb_back.sv
rtl/plan_view_point_binning_unit.sv
rtl/pvb_checker.sv
tb/tb_plan_view_point_binning_unit.sv
